// File: sv/dfpdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpdh_pkg
// Shared constants, operation codes and types of the decimal fixed-point
// double / halve / add unit.
// ----------------------------------------------------------------------------
package dfpdh_pkg;

    localparam int INT_DIGITS   = 20;
    localparam int FRAC_DIGITS  = 44;
    localparam int DIGIT_STORE  = 64;
    localparam int TOTAL_DIGITS = ((INT_DIGITS + FRAC_DIGITS) > DIGIT_STORE) ?
                                  DIGIT_STORE : (INT_DIGITS + FRAC_DIGITS);
    localparam int ONE_POS      = ((INT_DIGITS - 1) < TOTAL_DIGITS) ?
                                  (INT_DIGITS - 1) : (TOTAL_DIGITS - 1);
    localparam int ADDR_W       = $clog2(DIGIT_STORE);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int FUNC_W       = 3;
    localparam int DIGIT_W      = 4;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DOUBLE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_HALVE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

    localparam logic [DIGIT_W:0] DEC_BASE = 5'd10;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [ADDR_W-1:0]  addr_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        digit_t            pdig;
        digit_t            sdig;
        logic              cin;
    } alu_req_t;

    typedef struct packed {
        digit_t digit;
        logic   cout;
    } alu_rsp_t;

endpackage

// File: sv/dfpdh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpdh_if
// Request and result channels with valid / ready handshake.
// ----------------------------------------------------------------------------
interface dfpdh_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [dfpdh_pkg::FUNC_W-1:0]   func;
    logic [dfpdh_pkg::ADDR_W-1:0]   digit_index;

    modport source (output valid, output func, output digit_index, input ready);
    modport sink   (input valid, input func, input digit_index, output ready);
endinterface

interface dfpdh_res_if;
    logic                           valid;
    logic                           ready;
    logic [dfpdh_pkg::DIGIT_W-1:0]  digit;
    logic                           overflow;
    logic                           inexact;

    modport source (output valid, output digit, output overflow, output inexact,
                    input ready);
    modport sink   (input valid, input digit, input overflow, input inexact,
                    output ready);
endinterface

// File: sv/dfpdh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpdh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfpdh_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/dfpdh_digit_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfpdh_digit_alu
// Shared one-digit BCD unit: double with carry, add with carry, halve with
// remainder passed down.
// ----------------------------------------------------------------------------
module dfpdh_digit_alu (
    input  dfpdh_pkg::alu_req_t req,
    output dfpdh_pkg::alu_rsp_t rsp
);

    logic [dfpdh_pkg::DIGIT_W:0] sum_v;
    logic [dfpdh_pkg::DIGIT_W:0] half_v;

    // remainder of the upper digit is worth ten here
    assign half_v = (req.cin ? dfpdh_pkg::DEC_BASE : '0) + {1'b0, req.pdig};

    always_comb
    begin
        if (req.func == dfpdh_pkg::FUNC_DOUBLE)
        begin
            sum_v = {req.pdig, 1'b0} + {{dfpdh_pkg::DIGIT_W{1'b0}}, req.cin};
        end
        else
        begin
            sum_v = {1'b0, req.pdig} + {1'b0, req.sdig}
                  + {{dfpdh_pkg::DIGIT_W{1'b0}}, req.cin};
        end
    end

    always_comb
    begin
        if (req.func == dfpdh_pkg::FUNC_HALVE)
        begin
            rsp.digit = half_v[dfpdh_pkg::DIGIT_W:1];
            rsp.cout  = half_v[0];
        end
        else if (sum_v >= dfpdh_pkg::DEC_BASE)
        begin
            rsp.digit = dfpdh_pkg::DIGIT_W'(sum_v - dfpdh_pkg::DEC_BASE);
            rsp.cout  = 1'b1;
        end
        else
        begin
            rsp.digit = sum_v[dfpdh_pkg::DIGIT_W-1:0];
            rsp.cout  = 1'b0;
        end
    end

endmodule

// File: sv/decimal_fixed_point_double_halve_add_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_fixed_point_double_halve_add_unit
// BCD fixed-point power / sum registers with clear, double, halve, add and
// digit read.
// ----------------------------------------------------------------------------
// one request at a time: clear and unused codes go from acceptance straight to
// the done state, a digit read passes through the read state, and double,
// halve and add walk all TOTAL_DIGITS (64) digits with one shared digit unit
// through the power and sum RAMs, one digit per cycle. cmd.ready is high
// only while no request is in work. both digit stores sit in RAMs; per-digit
// valid flops make reset and clear take effect at once, so there is no
// clearing pass
module decimal_fixed_point_double_halve_add_unit (
    input  logic        clk,
    input  logic        rst_n,
    dfpdh_cmd_if.sink   cmd,
    dfpdh_res_if.source res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int AW = dfpdh_pkg::ADDR_W;
    localparam int CW = dfpdh_pkg::CNT_W;
    localparam int DW = dfpdh_pkg::DIGIT_W;

    logic [1:0]                     state_reg, state_next;
    logic [dfpdh_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic                           carry_reg, carry_next;
    logic                           rd_pend_reg, rd_pend_next;
    dfpdh_pkg::addr_t               rd_addr_reg, rd_addr_next;
    logic                           pv_rd_reg, pv_rd_next;
    logic                           sv_rd_reg, sv_rd_next;
    logic [dfpdh_pkg::DIGIT_STORE-1:0] pvalid_reg, pvalid_next;
    logic [dfpdh_pkg::DIGIT_STORE-1:0] svalid_reg, svalid_next;
    dfpdh_pkg::digit_t              rdig_reg, rdig_next;
    logic                           rovf_reg, rovf_next;
    logic                           rinx_reg, rinx_next;
    logic                           out_valid_reg, out_valid_next;
    dfpdh_pkg::digit_t              out_digit_reg, out_digit_next;
    logic                           out_ovf_reg, out_ovf_next;
    logic                           out_inx_reg, out_inx_next;

    dfpdh_pkg::addr_t   raddr;
    dfpdh_pkg::addr_t   step_addr;
    dfpdh_pkg::digit_t  p_rdata, s_rdata;
    dfpdh_pkg::digit_t  pdig, sdig;
    logic               p_we, s_we;
    logic               issuing;
    logic               descending;
    logic               accept;
    dfpdh_pkg::alu_req_t alu_req;
    dfpdh_pkg::alu_rsp_t alu_rsp;

    assign accept     = cmd.valid && cmd.ready;
    assign cmd.ready  = (state_reg == S_IDLE);
    assign descending = (func_reg != dfpdh_pkg::FUNC_HALVE);
    assign issuing    = (cnt_reg < CW'(dfpdh_pkg::TOTAL_DIGITS));
    assign step_addr  = descending ?
                        (AW'(dfpdh_pkg::TOTAL_DIGITS - 1) - cnt_reg[AW-1:0]) :
                        cnt_reg[AW-1:0];
    assign raddr      = (state_reg == S_IDLE) ? cmd.digit_index : step_addr;

    // entries never written since clear hold the reset value
    assign pdig = pv_rd_reg ? p_rdata :
                  ((rd_addr_reg == AW'(dfpdh_pkg::ONE_POS)) ? DW'(1) : '0);
    assign sdig = sv_rd_reg ? s_rdata : '0;

    assign alu_req.func = func_reg;
    assign alu_req.pdig = pdig;
    assign alu_req.sdig = sdig;
    assign alu_req.cin  = carry_reg;

    assign p_we = (state_reg == S_RUN) && rd_pend_reg && (func_reg != dfpdh_pkg::FUNC_ADD);
    assign s_we = (state_reg == S_RUN) && rd_pend_reg && (func_reg == dfpdh_pkg::FUNC_ADD);

    dfpdh_digit_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    dfpdh_ram #(
        .WIDTH (DW),
        .DEPTH (dfpdh_pkg::DIGIT_STORE)
    ) u_power_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (rd_addr_reg),
        .wdata (alu_rsp.digit),
        .raddr (raddr),
        .rdata (p_rdata)
    );

    dfpdh_ram #(
        .WIDTH (DW),
        .DEPTH (dfpdh_pkg::DIGIT_STORE)
    ) u_sum_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (rd_addr_reg),
        .wdata (alu_rsp.digit),
        .raddr (raddr),
        .rdata (s_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        cnt_next       = cnt_reg;
        carry_next     = carry_reg;
        rd_pend_next   = 1'b0;
        rd_addr_next   = raddr;
        pv_rd_next     = pvalid_reg[raddr];
        sv_rd_next     = svalid_reg[raddr];
        pvalid_next    = pvalid_reg;
        svalid_next    = svalid_reg;
        rdig_next      = rdig_reg;
        rovf_next      = rovf_reg;
        rinx_next      = rinx_reg;
        out_valid_next = out_valid_reg;
        out_digit_next = out_digit_reg;
        out_ovf_next   = out_ovf_reg;
        out_inx_next   = out_inx_reg;

        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (p_we)
        begin
            pvalid_next[rd_addr_reg] = 1'b1;
        end
        if (s_we)
        begin
            svalid_next[rd_addr_reg] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = cmd.func;
                    cnt_next   = '0;
                    carry_next = 1'b0;
                    rdig_next  = '0;
                    rovf_next  = 1'b0;
                    rinx_next  = 1'b0;
                    if (cmd.func == dfpdh_pkg::FUNC_DOUBLE ||
                        cmd.func == dfpdh_pkg::FUNC_HALVE ||
                        cmd.func == dfpdh_pkg::FUNC_ADD)
                    begin
                        state_next = S_RUN;
                    end
                    else if (cmd.func == dfpdh_pkg::FUNC_READ)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        if (cmd.func == dfpdh_pkg::FUNC_CLEAR)
                        begin
                            pvalid_next = '0;
                            svalid_next = '0;
                        end
                        state_next = S_DONE;
                    end
                end
            end
            S_RUN:
            begin
                if (issuing)
                begin
                    cnt_next     = cnt_reg + CW'(1);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    carry_next = alu_rsp.cout;
                    // last digit processed: carry or remainder is the flag
                    if (!issuing)
                    begin
                        rovf_next  = descending && alu_rsp.cout;
                        rinx_next  = !descending && alu_rsp.cout;
                        state_next = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                if ({1'b0, rd_addr_reg} < CW'(dfpdh_pkg::TOTAL_DIGITS))
                begin
                    rdig_next = sdig;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_digit_next = rdig_reg;
                    out_ovf_next   = rovf_reg;
                    out_inx_next   = rinx_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            carry_reg     <= 1'b0;
            rd_pend_reg   <= 1'b0;
            pvalid_reg    <= '0;
            svalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            carry_reg     <= carry_next;
            rd_pend_reg   <= rd_pend_next;
            pvalid_reg    <= pvalid_next;
            svalid_reg    <= svalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        rd_addr_reg   <= rd_addr_next;
        pv_rd_reg     <= pv_rd_next;
        sv_rd_reg     <= sv_rd_next;
        rdig_reg      <= rdig_next;
        rovf_reg      <= rovf_next;
        rinx_reg      <= rinx_next;
        out_digit_reg <= out_digit_next;
        out_ovf_reg   <= out_ovf_next;
        out_inx_reg   <= out_inx_next;
    end

    assign res.valid    = out_valid_reg;
    assign res.digit    = out_digit_reg;
    assign res.overflow = out_ovf_reg;
    assign res.inexact  = out_inx_reg;

endmodule
